[rtl/core/rdg_pkg.sv]
// Shared types, constants and hash helpers for the random DNA base generator.
`timescale 1ns / 1ps

package rdg_pkg;

  localparam int unsigned LaneCnt    = 4;
  localparam int unsigned LaneBytes  = 4;
  localparam int unsigned ChunkBytes = LaneCnt * LaneBytes;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_USER_SEED   = 3'd0,
    REG_NOISE_ONE   = 3'd1,
    REG_NOISE_TWO   = 3'd2,
    REG_NOISE_THREE = 3'd3,
    REG_NOISE_FOUR  = 3'd4
  } reg_idx_e;

  // Register reset values
  localparam logic [31:0] UserSeedRst   = 32'd0;
  localparam logic [31:0] NoiseOneRst   = 32'd3039394381;
  localparam logic [31:0] NoiseTwoRst   = 32'd1759714724;
  localparam logic [31:0] NoiseThreeRst = 32'd458671337;
  localparam logic [31:0] NoiseFourRst  = 32'd198491317;

  // ASCII letters
  localparam logic [7:0] LetterA = 8'h41;
  localparam logic [7:0] LetterC = 8'h43;
  localparam logic [7:0] LetterG = 8'h47;
  localparam logic [7:0] LetterT = 8'h54;

  typedef struct packed {
    logic [29:0] chunk_index;
    logic [4:0]  byte_count;
  } in_item_t;

  typedef struct packed {
    logic [63:0] bases_low;
    logic [63:0] bases_high;
    logic [4:0]  valid_bytes;
  } out_item_t;

  // Pipeline control handed to the merge stage
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctrl_t;

  // Middle part of the hash: shift-xor, add, shift-xor
  function automatic logic [31:0] mix_mid(input logic [31:0] sum, input logic [31:0] n2);
    logic [31:0] a;
    logic [31:0] b;
    a = sum ^ (sum >> 8);
    b = a + n2;
    return b ^ (b << 13);
  endfunction

  // Final shift-xor of the hash
  function automatic logic [31:0] mix_fin(input logic [31:0] prod);
    return prod ^ (prod >> 17);
  endfunction

  // Low two bits pick a base
  function automatic logic [7:0] base_letter(input logic [1:0] sel);
    logic [7:0] l;
    unique case (sel)
      2'd0: l = LetterA;
      2'd1: l = LetterC;
      2'd2: l = LetterG;
      2'd3: l = LetterT;
      default: l = LetterA;
    endcase
    return l;
  endfunction

endpackage

[rtl/core/rdg_premix.sv]
// Seed premix pipeline: hashes user_seed with noise_four as the seed operand.
`timescale 1ns / 1ps

module rdg_premix import rdg_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] user_seed_i,
  input  logic [31:0] noise_one_i,
  input  logic [31:0] noise_two_i,
  input  logic [31:0] noise_three_i,
  input  logic [31:0] noise_four_i,
  output logic [31:0] mixed_o
);

  logic [31:0] prod1_q, mid_q, prod2_q;

  // Three register levels, in step with the item pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q <= user_seed_i * noise_one_i;
      mid_q   <= mix_mid(prod1_q + noise_four_i, noise_two_i);
      prod2_q <= mid_q * noise_three_i;
    end
  end

  assign mixed_o = mix_fin(prod2_q);

endmodule

[rtl/core/rdg_lane.sv]
// One hash lane: turns a position and the mixed seed into a 32-bit noise word.
`timescale 1ns / 1ps

module rdg_lane import rdg_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] pos_i,
  input  logic [31:0] mixed_i,
  input  logic [31:0] noise_one_i,
  input  logic [31:0] noise_two_i,
  input  logic [31:0] noise_three_i,
  output logic [31:0] word_o
);

  logic [31:0] prod1_q, mid_q, prod2_q;

  // multiply, add seed and mix, multiply
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q <= pos_i * noise_one_i;
      mid_q   <= mix_mid(prod1_q + mixed_i, noise_two_i);
      prod2_q <= mid_q * noise_three_i;
    end
  end

  assign word_o = mix_fin(prod2_q);

endmodule

[rtl/core/rdg_merge.sv]
// Merge stage: maps lane bytes to ASCII bases, masks invalid bytes, output register.
`timescale 1ns / 1ps

module rdg_merge import rdg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pipe_ctrl_t  ctrl_i,
  input  logic [4:0]  cnt_i,
  input  logic [31:0] words_i [LaneCnt],
  output logic        out_valid_o,
  output out_item_t   out_data_o
);

  logic [8*ChunkBytes-1:0] bytes_d;
  out_item_t               data_q;
  logic                    valid_q;

  // Byte k comes from lane k/4, byte k%4; bytes at or past the count are zero
  always_comb begin
    bytes_d = '0;
    for (int k = 0; k < ChunkBytes; k++) begin
      if (5'(k) < cnt_i) begin
        bytes_d[8*k +: 8] = base_letter(words_i[k / LaneBytes][8*(k % LaneBytes) +: 2]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.en) begin
      valid_q <= ctrl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      data_q.bases_low   <= bytes_d[63:0];
      data_q.bases_high  <= bytes_d[127:64];
      data_q.valid_bytes <= cnt_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[rtl/core/random_dna_base_generator.sv]
// Top level of the random DNA base generator.
`timescale 1ns / 1ps

// Counter-based random DNA source. Each input transaction names a 16-byte chunk
// and a valid byte count; one output transaction returns 16 ASCII bases
// (A, C, G, T) for that chunk, bytes at or past the count zeroed. A new chunk
// is taken every cycle unless a result waits on a stalled output. The item
// path runs through two input registers holding index and count, three
// stages in each of the four lanes (multiply, mix, multiply), and a merge stage
// with the output register. The seed premix runs beside the lanes in three
// stages of its own and is recomputed whenever the pipeline advances, so
// configuration writes take effect for the next chunk accepted. The pipeline
// holds while a finished result waits on a stalled output.
module random_dna_base_generator import rdg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [31:0] user_seed_q, noise_one_q, noise_two_q, noise_three_q, noise_four_q;
  logic        en;
  logic [4:0]  vld_q;
  logic [29:0] idx_q [2];
  logic [4:0]  cnt_q [5];
  logic [31:0] mixed;
  logic [31:0] words [LaneCnt];
  pipe_ctrl_t  merge_ctrl;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_seed_q   <= UserSeedRst;
      noise_one_q   <= NoiseOneRst;
      noise_two_q   <= NoiseTwoRst;
      noise_three_q <= NoiseThreeRst;
      noise_four_q  <= NoiseFourRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_USER_SEED:   user_seed_q   <= cfg_data_i;
        REG_NOISE_ONE:   noise_one_q   <= cfg_data_i;
        REG_NOISE_TWO:   noise_two_q   <= cfg_data_i;
        REG_NOISE_THREE: noise_three_q <= cfg_data_i;
        REG_NOISE_FOUR:  noise_four_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless a result sits stalled at the output
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  // Item payload travelling alongside the hash stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      idx_q[0] <= in_data_i.chunk_index;
      idx_q[1] <= idx_q[0];
      cnt_q[0] <= in_data_i.byte_count;
      for (int s = 1; s < 5; s++) begin
        cnt_q[s] <= cnt_q[s-1];
      end
    end
  end

  rdg_premix u_premix (
    .clk_i         (clk_i),
    .en_i          (en),
    .user_seed_i   (user_seed_q),
    .noise_one_i   (noise_one_q),
    .noise_two_i   (noise_two_q),
    .noise_three_i (noise_three_q),
    .noise_four_i  (noise_four_q),
    .mixed_o       (mixed)
  );

  // Four lanes hash positions 4*index+0..3
  for (genvar k = 0; k < LaneCnt; k++) begin : g_lane
    rdg_lane u_lane (
      .clk_i         (clk_i),
      .en_i          (en),
      .pos_i         ({idx_q[1], 2'(k)}),
      .mixed_i       (mixed),
      .noise_one_i   (noise_one_q),
      .noise_two_i   (noise_two_q),
      .noise_three_i (noise_three_q),
      .word_o        (words[k])
    );
  end

  assign merge_ctrl.en  = en;
  assign merge_ctrl.vld = vld_q[4];

  rdg_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (merge_ctrl),
    .cnt_i       (cnt_q[4]),
    .words_i     (words),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/core/rdg_checker.sv]
// Port-level checker for the random DNA base generator, bound to the top level.
`timescale 1ns / 1ps

module rdg_checker import rdg_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // A stalled output transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");

  // Input is only held back by a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // With no back-pressure an accepted chunk reaches the output with its count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !in_stall_o ##1 !in_stall_o ##1 !in_stall_o
      ##1 !in_stall_o ##1 !in_stall_o
    |=> out_valid_o && out_data_o.valid_bytes == $past(in_data_i.byte_count, 6))
    else $error("result missing or count mismatch after six cycles");

  // Counts of eight or less leave the upper half empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.valid_bytes <= 5'd8 |-> out_data_o.bases_high == 64'd0)
    else $error("bytes past the count not zero");

  // First byte is a base letter whenever any byte is valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.valid_bytes != 5'd0 |->
      out_data_o.bases_low[7:0] == LetterA || out_data_o.bases_low[7:0] == LetterC ||
      out_data_o.bases_low[7:0] == LetterG || out_data_o.bases_low[7:0] == LetterT)
    else $error("first byte is not a base letter");

endmodule

bind random_dna_base_generator rdg_checker u_rdg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[dv/random_dna_base_generator_test.sv]
// Self-checking testbench for the random DNA base generator.
`timescale 1ns / 1ps

module random_dna_base_generator_test;
  import rdg_pkg::*;

  localparam int unsigned NumRegs    = int'(REG_NOISE_FOUR) + 1;
  localparam int unsigned DrainWait  = 24;       // several times the pipeline latency
  localparam int unsigned PhaseItems = 140;
  localparam int unsigned MaxReports = 10;
  localparam logic [29:0] IndexMax   = '1;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // chunk requests waiting for the driver, and predicted chunks waiting for the output
  in_item_t  chunk_requests[$];
  out_item_t predicted_chunks[$];
  int unsigned fail_cnt = 0;

  // predictor copy of the configuration
  logic [31:0] cfg_seed    = UserSeedRst;
  logic [31:0] cfg_mul_a   = NoiseOneRst;
  logic [31:0] cfg_addend  = NoiseTwoRst;
  logic [31:0] cfg_mul_b   = NoiseThreeRst;
  logic [31:0] cfg_premix  = NoiseFourRst;

  random_dna_base_generator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Squirrel-style position hash, mod 2^32
  function automatic logic [31:0] squirrel_mix(input logic [31:0] pos,
                                               input logic [31:0] seed);
    logic [31:0] x;
    x = pos * cfg_mul_a;
    x = x + seed;
    x = x ^ (x >> 8);
    x = x + cfg_addend;
    x = x ^ (x << 13);
    x = x * cfg_mul_b;
    x = x ^ (x >> 17);
    return x;
  endfunction

  function automatic logic [7:0] dna_letter(input logic [1:0] sel);
    logic [7:0] l;
    case (sel)
      2'd0:    l = "A";
      2'd1:    l = "C";
      2'd2:    l = "G";
      default: l = "T";
    endcase
    return l;
  endfunction

  // Expected bases for one chunk under the current configuration
  function automatic out_item_t predict_bases(input in_item_t req);
    out_item_t    res;
    logic [31:0]  mixed;
    logic [31:0]  lane;
    logic [127:0] chunk;
    int unsigned  cnt;
    cnt   = (req.byte_count > ChunkBytes) ? ChunkBytes : req.byte_count;
    mixed = squirrel_mix(cfg_seed, cfg_premix);
    chunk = '0;
    for (int unsigned k = 0; k < ChunkBytes; k++) begin
      lane = squirrel_mix({req.chunk_index, 2'b00} + 32'(k / LaneBytes), mixed);
      if (k < cnt) chunk[k*8 +: 8] = dna_letter(lane[(k % LaneBytes)*8 +: 2]);
    end
    res.bases_low   = chunk[63:0];
    res.bases_high  = chunk[127:64];
    res.valid_bytes = req.byte_count;
    return res;
  endfunction

  task automatic note_failure(input string what);
    fail_cnt++;
    if (fail_cnt <= MaxReports) $display("%0t ns: ERROR %s", $time, what);
  endtask

  // Driver: bursts of random length separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left > 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (chunk_requests.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= chunk_requests.pop_front();
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: free-running stretches, short stalls, long stalls
  int unsigned stall_left = 0;
  int unsigned cycle_cnt  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      cycle_cnt   <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt[9:8] == 2'd0) begin
        // quiet window, no backpressure at all
        out_stall_i <= 1'b0;
        stall_left  <= 0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            out_stall_i <= 1'b0;
            stall_left  <= $urandom_range(0, 30);
          end
          4, 5, 6, 7: begin
            out_stall_i <= 1'b1;
            stall_left  <= $urandom_range(0, 3);
          end
          default: begin
            out_stall_i <= 1'b1;
            stall_left  <= $urandom_range(4, 20);
          end
        endcase
      end
    end
  end

  // Monitor: predict on input transactions, check output transactions in order
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predicted_chunks.push_back(predict_bases(in_data_i));
      if (out_valid_o && !out_stall_i) begin
        if (predicted_chunks.size() == 0) begin
          note_failure($sformatf("unexpected output transaction %h", out_data_o));
        end else begin
          want = predicted_chunks.pop_front();
          if (out_data_o.bases_low !== want.bases_low)
            note_failure($sformatf("bases_low exp %h got %h",
                                   want.bases_low, out_data_o.bases_low));
          if (out_data_o.bases_high !== want.bases_high)
            note_failure($sformatf("bases_high exp %h got %h",
                                   want.bases_high, out_data_o.bases_high));
          if (out_data_o.valid_bytes !== want.valid_bytes)
            note_failure($sformatf("valid_bytes exp %0d got %0d",
                                   want.valid_bytes, out_data_o.valid_bytes));
        end
      end
    end
  end

  // Block until the sender is idle and every predicted chunk has come out
  task automatic wait_drained();
    do @(negedge clk_i);
    while (chunk_requests.size() > 0 || in_valid_i || predicted_chunks.size() > 0);
  endtask

  // One register write; predictor follows once the write edge has passed
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_USER_SEED:   cfg_seed   = val;
      REG_NOISE_ONE:   cfg_mul_a  = val;
      REG_NOISE_TWO:   cfg_addend = val;
      REG_NOISE_THREE: cfg_mul_b  = val;
      REG_NOISE_FOUR:  cfg_premix = val;
      default: ;  // unmapped index, ignored
    endcase
  endtask

  task automatic write_all(input logic [31:0] seed, input logic [31:0] n1,
                           input logic [31:0] n2, input logic [31:0] n3,
                           input logic [31:0] n4);
    write_reg(REG_USER_SEED, seed);
    write_reg(REG_NOISE_ONE, n1);
    write_reg(REG_NOISE_TWO, n2);
    write_reg(REG_NOISE_THREE, n3);
    write_reg(REG_NOISE_FOUR, n4);
  endtask

  function automatic in_item_t make_chunk(input logic [29:0] idx, input logic [4:0] cnt);
    in_item_t it;
    it.chunk_index = idx;
    it.byte_count  = cnt;
    return it;
  endfunction

  // Random chunks: mostly legal counts, some zero and oversized ones
  task automatic queue_random(input int unsigned n);
    logic [29:0] idx;
    logic [4:0]  cnt;
    @(negedge clk_i);
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0:       idx = 30'($urandom_range(0, 255));
        1:       idx = IndexMax - 30'($urandom_range(0, 255));
        default: idx = 30'($urandom());
      endcase
      if ($urandom_range(0, 7) == 0) cnt = 5'($urandom_range(0, 31));
      else cnt = 5'($urandom_range(1, ChunkBytes));
      chunk_requests.push_back(make_chunk(idx, cnt));
    end
  endtask

  // Stimulus sequence
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: index extremes, every count edge, zero and saturating counts
    @(negedge clk_i);
    chunk_requests.push_back(make_chunk('0, 5'd16));
    chunk_requests.push_back(make_chunk(IndexMax, 5'd16));
    chunk_requests.push_back(make_chunk(30'h15555555, 5'd16));
    chunk_requests.push_back(make_chunk(30'h2aaaaaaa, 5'd16));
    chunk_requests.push_back(make_chunk(30'd1, 5'd0));
    chunk_requests.push_back(make_chunk(30'd2, 5'd1));
    chunk_requests.push_back(make_chunk(30'd3, 5'd4));
    chunk_requests.push_back(make_chunk(30'd4, 5'd7));
    chunk_requests.push_back(make_chunk(30'd5, 5'd8));
    chunk_requests.push_back(make_chunk(30'd6, 5'd9));
    chunk_requests.push_back(make_chunk(30'd7, 5'd15));
    chunk_requests.push_back(make_chunk(30'd8, 5'd17));
    chunk_requests.push_back(make_chunk(30'd9, 5'd31));
    chunk_requests.push_back(make_chunk(IndexMax, 5'd1));
    chunk_requests.push_back(make_chunk(IndexMax, 5'd0));
    chunk_requests.push_back(make_chunk(IndexMax, 5'd31));
    chunk_requests.push_back(make_chunk(30'h20000000, 5'd12));
    chunk_requests.push_back(make_chunk(30'h3ffffffe, 5'd16));
    queue_random(PhaseItems);
    wait_drained();

    // writes to unmapped indexes must leave the configuration alone
    for (int unsigned i = NumRegs; i < 2**CfgIdxW; i++) write_reg(CfgIdxW'(i), $urandom());
    queue_random(PhaseItems);
    wait_drained();

    // all-zero configuration
    write_all('0, '0, '0, '0, '0);
    queue_random(PhaseItems);
    wait_drained();

    // all-ones configuration
    write_all('1, '1, '1, '1, '1);
    queue_random(PhaseItems);
    wait_drained();

    // extreme seed, random constants
    write_all('1, $urandom(), $urandom(), $urandom(), $urandom());
    queue_random(PhaseItems);
    wait_drained();

    // fully random configuration
    write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    queue_random(PhaseItems);
    wait_drained();

    // random subset of registers rewritten
    for (int unsigned i = 0; i < NumRegs; i++)
      if ($urandom_range(0, 1) == 1) write_reg(CfgIdxW'(i), $urandom());
    queue_random(PhaseItems);
    wait_drained();

    // back to power-on constants
    write_all(UserSeedRst, NoiseOneRst, NoiseTwoRst, NoiseThreeRst, NoiseFourRst);
    queue_random(PhaseItems);
    wait_drained();

    repeat (DrainWait) @(posedge clk_i);
    if (predicted_chunks.size() > 0)
      note_failure($sformatf("%0d chunks never came out", predicted_chunks.size()));
    if (fail_cnt == 0) begin
      $display("random_dna_base_generator test passed");
    end else begin
      $display("random_dna_base_generator test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("random_dna_base_generator test failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/rdg_pkg.sv
rtl/core/rdg_premix.sv
rtl/core/rdg_lane.sv
rtl/core/rdg_merge.sv
rtl/core/random_dna_base_generator.sv
rtl/core/rdg_checker.sv
dv/random_dna_base_generator_test.sv
